/* rtl/tilt_pid_servo_controller_defines.svh */
// Assertion macros for the tilt servo controller.
`ifndef TILT_PID_SERVO_CONTROLLER_DEFINES_SVH
`define TILT_PID_SERVO_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TPS_ASSERT_IMP(label, clk, rst_n, a, c)
`define TPS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/tps_pkg.sv */
// Package with types, constants and tables for the tilt servo controller.
`timescale 1ns / 1ps
package tps_pkg;
    localparam int CordicSteps = 16;
    localparam int IntegralLimit = 3000;
    localparam int AccW = 48;

    localparam logic [2:0] REG_GYRO_OFFSET = 3'd0;
    localparam logic [2:0] REG_POT_LOW = 3'd1;
    localparam logic [2:0] REG_POT_HIGH = 3'd2;
    localparam logic [2:0] REG_GAIN_PROP = 3'd3;
    localparam logic [2:0] REG_GAIN_INTEG = 3'd4;
    localparam logic [2:0] REG_GAIN_DERIV = 3'd5;
    localparam logic [2:0] REG_FILTER_ALPHA = 3'd6;
    localparam logic [2:0] REG_DEADBAND = 3'd7;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_INC,
        ST_BLEND_A,
        ST_BLEND_A_WAIT,
        ST_BLEND_B,
        ST_BLEND_B_WAIT,
        ST_FILT,
        ST_SP_START,
        ST_SP_RUN,
        ST_ERR,
        ST_PID_P,
        ST_PID_P_WAIT,
        ST_PID_I,
        ST_PID_I_WAIT,
        ST_PID_D,
        ST_PID_D_WAIT,
        ST_TGT,
        ST_PWM_START,
        ST_PWM_RUN,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    function automatic logic [24:0] atan_entry(input logic [4:0] i);
        logic [24:0] r;
        begin
            case (i)
                5'd0: r = 25'd2949120;
                5'd1: r = 25'd1740967;
                5'd2: r = 25'd919879;
                5'd3: r = 25'd466945;
                5'd4: r = 25'd234379;
                5'd5: r = 25'd117265;
                5'd6: r = 25'd58666;
                5'd7: r = 25'd29335;
                5'd8: r = 25'd14668;
                5'd9: r = 25'd7334;
                5'd10: r = 25'd3667;
                5'd11: r = 25'd1833;
                5'd12: r = 25'd917;
                5'd13: r = 25'd458;
                5'd14: r = 25'd229;
                5'd15: r = 25'd115;
                5'd16: r = 25'd57;
                5'd17: r = 25'd29;
                5'd18: r = 25'd14;
                5'd19: r = 25'd7;
                5'd20: r = 25'd4;
                5'd21: r = 25'd2;
                5'd22: r = 25'd1;
                default: r = 25'd0;
            endcase
            return r;
        end
    endfunction
endpackage

/* rtl/tps_mul.sv */
// Bit-serial signed-by-unsigned multiplier.
`timescale 1ns / 1ps
module tps_mul
    import tps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [AccW-1:0] multiplicand,
    input  logic        [16:0]     multiplier,
    output logic                   done,
    output logic signed [AccW-1:0] product
);
    mul_state_t state_reg, state_next;
    logic [4:0] count_reg, count_next;
    logic signed [AccW-1:0] mcand_reg, mcand_next;
    logic [16:0] mplier_reg, mplier_next;
    logic signed [AccW-1:0] acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        acc_next = acc_reg;
        done = 1'b0;
        unique case (state_reg)
            MUL_IDLE:
            begin
                if (start)
                begin
                    mcand_next = multiplicand;
                    mplier_next = multiplier;
                    acc_next = '0;
                    count_next = '0;
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                count_next = count_reg + 5'd1;
                if (count_reg == 5'd16)
                begin
                    state_next = MUL_DONE;
                end
            end
            MUL_DONE:
            begin
                done = 1'b1;
                state_next = MUL_IDLE;
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
    end

    assign product = acc_reg;
endmodule

/* rtl/tps_div.sv */
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module tps_div
    import tps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [47:0] quotient
);
    logic [5:0] count_reg, count_next;
    logic [47:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsor_reg, dsor_next;
    logic [16:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dsor_reg <= dsor_next;
    end

    always_comb
    begin
        count_next = count_reg;
        quot_next = quot_reg;
        rem_next = rem_reg;
        dsor_next = dsor_reg;
        trial = {rem_reg[15:0], quot_reg[47]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next = '0;
            dsor_next = req.divisor;
            count_next = 6'd48;
        end
        else if (count_reg != 6'd0)
        begin
            if (trial >= {1'b0, dsor_reg})
            begin
                rem_next = trial - {1'b0, dsor_reg};
                quot_next = {quot_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quot_next = {quot_reg[46:0], 1'b0};
            end
            count_next = count_reg - 6'd1;
        end
    end

    assign busy = (count_reg != 6'd0);
    assign quotient = quot_reg;
endmodule

/* rtl/tps_cordic.sv */
// Vectoring CORDIC that iterates one rotation per cycle to give the pitch.
`timescale 1ns / 1ps
module tps_cordic
    import tps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [15:0]  ay,
    input  logic signed [15:0]  az,
    output logic                done,
    output logic signed [23:0]  pitch
);
    localparam int StepW = $clog2(CordicSteps + 1);

    logic signed [27:0] x_reg, x_next, y_reg, y_next;
    logic signed [27:0] z_reg, z_next;
    logic [StepW-1:0] i_reg, i_next;
    logic run_reg, run_next;
    logic zero_reg, zero_next;
    logic done_reg, done_next;
    logic signed [27:0] xs, ys, x0, y0;
    logic signed [27:0] zr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        run_next = run_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        x0 = 28'(az) <<< 8;
        y0 = 28'(ay) <<< 8;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (start)
        begin
            zero_next = (ay == 16'sd0) && (az == 16'sd0);
            i_next = '0;
            run_next = 1'b1;
            if (az < 0)
            begin
                x_next = -x0;
                y_next = -y0;
                z_next = (ay >= 0) ? 28'sd11796480 : -28'sd11796480;
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (run_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + 28'(atan_entry(5'(i_reg)));
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - 28'(atan_entry(5'(i_reg)));
            end
            i_next = i_reg + StepW'(1);
            if (i_reg == StepW'(CordicSteps - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign zr = (z_reg + 28'sd128) >>> 8;
    assign pitch = zero_reg ? 24'sd0 : -24'(zr);
    assign done = done_reg;
endmodule

/* rtl/tilt_pid_servo_controller.sv */
// Top level of the tilt servo controller: registers, sequencer and outputs.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/ready   | gyro_x, accel_y, accel_z, pot_sample
// out     | output    | out_valid/ready  | pulse_width, filtered_angle, angle_byte, target_byte
// cfg     | input     | APB psel/penable | paddr, pwdata, prdata
//
// Each accepted item passes through three divides and five serial multiplies, with
// the 16-step CORDIC running under the first divide, and a new item is accepted only
// after the previous one has finished. An empty pot range skips one divide.
// Reset clears the state and loads the register defaults.
// The next item is taken while a result waits in the output register; a second
// finished result then stalls in the last step until the first one is taken.
`timescale 1ns / 1ps
`include "tilt_pid_servo_controller_defines.svh"
module tilt_pid_servo_controller
    import tps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic        [11:0] pot_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [11:0] pulse_width,
    output logic signed [23:0] filtered_angle,
    output logic        [7:0]  angle_byte,
    output logic        [6:0]  target_byte,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    localparam logic signed [AccW-1:0] AMax = AccW'(8388607);
    localparam logic signed [AccW-1:0] AMin = -AccW'(8388608);
    localparam logic signed [AccW-1:0] ILim = AccW'(IntegralLimit * 256);

    logic signed [19:0] gyro_offset_reg;
    logic [11:0] pot_low_reg, pot_high_reg, deadband_reg;
    logic [15:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [16:0] filter_alpha_reg;
    logic signed [23:0] tilt_reg, tilt_next;
    logic signed [23:0] prev_err_reg, prev_err_next;
    logic signed [21:0] integ_reg, integ_next;

    ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic [11:0] pwm_reg, pwm_next;
    logic signed [23:0] filt_out_reg, filt_out_next;
    logic [7:0] ab_reg, ab_next;
    logic [6:0] tb_reg, tb_next;

    logic signed [15:0] gx_reg, gx_next, ay_reg, ay_next, az_reg, az_next;
    logic [11:0] pot_reg, pot_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [AccW-1:0] t_reg, t_next;
    logic dneg_reg, dneg_next;
    logic signed [23:0] pitch_reg, pitch_next;
    logic signed [23:0] filt_reg, filt_next;
    logic [6:0] sp_reg, sp_next;
    logic signed [23:0] err_reg, err_next;

    logic wr_en;
    logic [2:0] wr_idx;
    logic in_fire, out_fire;
    logic cordic_start, cordic_done;
    logic signed [23:0] cordic_pitch;
    div_req_t div_req;
    logic div_busy;
    logic [47:0] div_q;
    logic mul_start, mul_done;
    logic signed [AccW-1:0] mul_a, mul_p;
    logic [16:0] mul_b;
    logic [16:0] alpha_eff;
    logic signed [AccW-1:0] d_val, dmag, sum, ftmp, etmp, itmp, abtmp;
    logic [11:0] pclamp;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign alpha_eff = filter_alpha_reg[16] ? 17'h10000 : filter_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_offset_reg <= '0;
            pot_low_reg <= '0;
            pot_high_reg <= 12'd4095;
            gain_prop_reg <= 16'd4096;
            gain_integ_reg <= 16'd205;
            gain_deriv_reg <= 16'd819;
            filter_alpha_reg <= 17'd62259;
            deadband_reg <= 12'd384;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_GYRO_OFFSET: gyro_offset_reg <= pwdata[19:0];
                REG_POT_LOW: pot_low_reg <= pwdata[11:0];
                REG_POT_HIGH: pot_high_reg <= pwdata[11:0];
                REG_GAIN_PROP: gain_prop_reg <= pwdata[15:0];
                REG_GAIN_INTEG: gain_integ_reg <= pwdata[15:0];
                REG_GAIN_DERIV: gain_deriv_reg <= pwdata[15:0];
                REG_FILTER_ALPHA: filter_alpha_reg <= pwdata[16:0];
                REG_DEADBAND: deadband_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_GYRO_OFFSET: prdata = 32'(signed'(gyro_offset_reg));
            REG_POT_LOW: prdata = 32'(pot_low_reg);
            REG_POT_HIGH: prdata = 32'(pot_high_reg);
            REG_GAIN_PROP: prdata = 32'(gain_prop_reg);
            REG_GAIN_INTEG: prdata = 32'(gain_integ_reg);
            REG_GAIN_DERIV: prdata = 32'(gain_deriv_reg);
            REG_FILTER_ALPHA: prdata = 32'(filter_alpha_reg);
            REG_DEADBAND: prdata = 32'(deadband_reg);
            default: prdata = '0;
        endcase
    end

    tps_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start), .ay(ay_reg), .az(az_reg),
        .done(cordic_done), .pitch(cordic_pitch)
    );

    tps_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy), .quotient(div_q)
    );

    tps_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .multiplicand(mul_a),
        .multiplier(mul_b), .done(mul_done), .product(mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tilt_reg <= '0;
            prev_err_reg <= '0;
            integ_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            tilt_reg <= tilt_next;
            prev_err_reg <= prev_err_next;
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pwm_reg <= pwm_next;
        filt_out_reg <= filt_out_next;
        ab_reg <= ab_next;
        tb_reg <= tb_next;
        gx_reg <= gx_next;
        ay_reg <= ay_next;
        az_reg <= az_next;
        pot_reg <= pot_next;
        acc_reg <= acc_next;
        t_reg <= t_next;
        dneg_reg <= dneg_next;
        pitch_reg <= pitch_next;
        filt_reg <= filt_next;
        sp_reg <= sp_next;
        err_reg <= err_next;
    end

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        tilt_next = tilt_reg;
        prev_err_next = prev_err_reg;
        integ_next = integ_reg;
        pwm_next = pwm_reg;
        filt_out_next = filt_out_reg;
        ab_next = ab_reg;
        tb_next = tb_reg;
        gx_next = gx_reg;
        ay_next = ay_reg;
        az_next = az_reg;
        pot_next = pot_reg;
        acc_next = acc_reg;
        t_next = t_reg;
        dneg_next = dneg_reg;
        pitch_next = pitch_reg;
        filt_next = filt_reg;
        sp_next = sp_reg;
        err_next = err_reg;
        cordic_start = 1'b0;
        div_req = '0;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        d_val = (AccW'(gx_reg) <<< 4) - AccW'(gyro_offset_reg);
        dmag = d_val[AccW-1] ? -d_val : d_val;
        sum = '0;
        ftmp = '0;
        etmp = '0;
        itmp = '0;
        abtmp = '0;
        pclamp = (pot_reg < pot_low_reg) ? pot_low_reg :
                 ((pot_reg > pot_high_reg) ? pot_high_reg : pot_reg);
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    gx_next = gyro_x;
                    ay_next = accel_y;
                    az_next = accel_z;
                    pot_next = pot_sample;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cordic_start = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                dneg_next = d_val[AccW-1];
                div_req.start = 1'b1;
                div_req.dividend = 48'((dmag <<< 4) + AccW'(3275));
                div_req.divisor = 16'd6550;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (cordic_done)
                begin
                    pitch_next = cordic_pitch;
                end
                if (!div_busy)
                begin
                    state_next = ST_INC;
                end
            end
            ST_INC:
            begin
                t_next = dneg_reg ? AccW'(signed'(div_q)) :
                         -AccW'(signed'(div_q));
                state_next = ST_BLEND_A;
            end
            ST_BLEND_A:
            begin
                mul_start = 1'b1;
                mul_a = AccW'(tilt_reg) + t_reg;
                mul_b = alpha_eff;
                state_next = ST_BLEND_A_WAIT;
            end
            ST_BLEND_A_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_p;
                    state_next = ST_BLEND_B;
                end
            end
            ST_BLEND_B:
            begin
                mul_start = 1'b1;
                mul_a = AccW'(pitch_reg);
                mul_b = 17'h10000 - alpha_eff;
                state_next = ST_BLEND_B_WAIT;
            end
            ST_BLEND_B_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = acc_reg + mul_p + AccW'(32768);
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                ftmp = acc_reg >>> 16;
                if (ftmp > AMax)
                begin
                    ftmp = AMax;
                end
                else if (ftmp < AMin)
                begin
                    ftmp = AMin;
                end
                filt_next = 24'(ftmp);
                tilt_next = 24'(ftmp);
                state_next = ST_SP_START;
            end
            ST_SP_START:
            begin
                if (pot_high_reg > pot_low_reg)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = 48'(pclamp - pot_low_reg) * 48'd90;
                    div_req.divisor = 16'(pot_high_reg - pot_low_reg);
                    state_next = ST_SP_RUN;
                end
                else
                begin
                    sp_next = '0;
                    state_next = ST_ERR;
                end
            end
            ST_SP_RUN:
            begin
                if (!div_busy)
                begin
                    sp_next = div_q[6:0];
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                etmp = (AccW'(sp_reg) <<< 8) - AccW'(filt_reg);
                if (etmp > AMax)
                begin
                    etmp = AMax;
                end
                else if (etmp < AMin)
                begin
                    etmp = AMin;
                end
                itmp = etmp[AccW-1] ? -etmp : etmp;
                if (itmp < AccW'(deadband_reg))
                begin
                    etmp = '0;
                end
                err_next = 24'(etmp);
                state_next = ST_PID_P;
            end
            ST_PID_P:
            begin
                mul_start = 1'b1;
                mul_a = AccW'(err_reg);
                mul_b = 17'(gain_prop_reg);
                state_next = ST_PID_P_WAIT;
            end
            ST_PID_P_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_p + AccW'(2048);
                    state_next = ST_PID_I;
                end
            end
            ST_PID_I:
            begin
                mul_start = 1'b1;
                mul_a = AccW'(integ_reg);
                mul_b = 17'(gain_integ_reg);
                state_next = ST_PID_I_WAIT;
            end
            ST_PID_I_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = acc_reg + mul_p;
                    state_next = ST_PID_D;
                end
            end
            ST_PID_D:
            begin
                mul_start = 1'b1;
                mul_a = AccW'(err_reg) - AccW'(prev_err_reg);
                mul_b = 17'(gain_deriv_reg);
                state_next = ST_PID_D_WAIT;
            end
            ST_PID_D_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = acc_reg + mul_p;
                    itmp = AccW'(integ_reg) + AccW'(err_reg);
                    if (itmp > ILim)
                    begin
                        itmp = ILim;
                    end
                    else if (itmp < -ILim)
                    begin
                        itmp = -ILim;
                    end
                    integ_next = 22'(itmp);
                    prev_err_next = err_reg;
                    state_next = ST_TGT;
                end
            end
            ST_TGT:
            begin
                sum = (signed'(AccW'(sp_reg)) <<< 8) + (acc_reg >>> 12);
                if (sum < 0)
                begin
                    sum = '0;
                end
                else if (sum > AccW'(46080))
                begin
                    sum = AccW'(46080);
                end
                t_next = sum >>> 8;
                state_next = ST_PWM_START;
            end
            ST_PWM_START:
            begin
                div_req.start = 1'b1;
                div_req.dividend = 48'(t_reg[7:0]) * 48'd1900;
                div_req.divisor = 16'd180;
                state_next = ST_PWM_RUN;
            end
            ST_PWM_RUN:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    pwm_next = 12'd500 + div_q[11:0];
                    filt_out_next = filt_reg;
                    abtmp = (AccW'(filt_reg) + AccW'(128)) >>> 8;
                    if (abtmp < 0)
                    begin
                        ab_next = 8'd0;
                    end
                    else if (abtmp > AccW'(255))
                    begin
                        ab_next = 8'd255;
                    end
                    else
                    begin
                        ab_next = abtmp[7:0];
                    end
                    tb_next = sp_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pulse_width = pwm_reg;
    assign filtered_angle = filt_out_reg;
    assign angle_byte = ab_reg;
    assign target_byte = tb_reg;

    `TPS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `TPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `TPS_ASSERT_IMP(a_pwm_range, clk, rst_n, out_valid,
                    pulse_width >= 12'd500 && pulse_width <= 12'd2400)
    `TPS_ASSERT_IMP(a_target_range, clk, rst_n, out_valid, target_byte <= 7'd90)
endmodule
